// ===== src/drcg_pkg.sv =====
// ----------------------------------------------------------------------------
// Digital rain cell generator package
// Transfer types, style codes, hash constants and the glyph lookup shared
// by the cell generator.
// ----------------------------------------------------------------------------
package drcg_pkg;

  // Field widths of a cell request and response
  localparam int FRAME_W = 32;
  localparam int COL_W   = 4;
  localparam int ROW_W   = 3;
  localparam int GLYPH_W = 7;
  localparam int PIXX_W  = 7;
  localparam int PIXY_W  = 6;

  // Number of distinct column codes
  localparam int COL_CODES = 2 ** COL_W;

  // Integer hash multipliers
  localparam logic [31:0] HASH_MUL_A = 32'h7FEB352D;
  localparam logic [31:0] HASH_MUL_B = 32'h846CA68B;

  // Column seed scrambling
  localparam logic [31:0] COL_MUL = 32'h91E10DA5;
  localparam logic [31:0] COL_ADD = 32'h4D415452;

  // Row weight in the glyph hash input
  localparam logic [4:0] ROW_WEIGHT = 5'd17;

  // Trail positions below this distance from the head are always drawn
  localparam int NEAR_TAIL = 3;

  // Bit of the glyph hash that keeps a far-tail cell visible
  localparam int KEEP_BIT = 9;

  typedef enum logic [1:0] {
    STYLE_BLANK  = 2'd0,
    STYLE_NORMAL = 2'd1,
    STYLE_HEAD   = 2'd2
  } style_e;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_index;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
  } cell_req_t;

  typedef struct packed {
    style_e             style;
    logic [GLYPH_W-1:0] glyph_code;
    logic [PIXX_W-1:0]  pixel_x;
    logic [PIXY_W-1:0]  pixel_y;
  } cell_rsp_t;

  // Full 32-bit integer hash; used at elaboration for the column seeds
  function automatic logic [31:0] hash32(input logic [31:0] x_in);
    logic [31:0] x;
    x = x_in;
    x = x ^ (x >> 16);
    x = x * HASH_MUL_A;
    x = x ^ (x >> 15);
    x = x * HASH_MUL_B;
    return x ^ (x >> 16);
  endfunction

  // Sixteen-character glyph set, ASCII
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [3:0] sel);
    logic [GLYPH_W-1:0] code;
    case (sel)
      4'd0:    code = 7'h30;
      4'd1:    code = 7'h31;
      4'd2:    code = 7'h32;
      4'd3:    code = 7'h33;
      4'd4:    code = 7'h34;
      4'd5:    code = 7'h35;
      4'd6:    code = 7'h36;
      4'd7:    code = 7'h37;
      4'd8:    code = 7'h38;
      4'd9:    code = 7'h39;
      4'd10:   code = 7'h2B;
      4'd11:   code = 7'h2D;
      4'd12:   code = 7'h2F;
      4'd13:   code = 7'h2A;
      4'd14:   code = 7'h3C;
      default: code = 7'h3E;
    endcase
    return code;
  endfunction

endpackage

// ===== src/digital_rain_cell_generator.sv =====
// ----------------------------------------------------------------------------
// Digital rain cell generator
// Per text cell (frame, column, row) decides style and glyph of a falling
// trail. Column constants are elaborated tables; the runtime path is a
// ten-register pipeline.
// ----------------------------------------------------------------------------
// Path: a start transfer is registered in s0, then in s1 to s8, then in the result register that drives done_o.
// Throughput: one cell per clock; busy stays low and a cell can start every
// cycle. The depth is set by the two reciprocal divisions and the two hash
// multiplies, each with a register of its own.
// Reset: rst_ni clears all valid bits and done_o; no results are lost later.
// done_o marks each result for one cycle; the receiver cannot stall.
module digital_rain_cell_generator #(
  parameter int COLUMNS = 16,
  parameter int ROWS    = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  drcg_pkg::cell_req_t cell_i,
  output logic                done_o,
  output drcg_pkg::cell_rsp_t result_o
);

  import drcg_pkg::*;

  // Derived widths
  localparam int CYC_MAX = ROWS + 10;             // largest trail cycle
  localparam int NMAX    = 5 * CYC_MAX;           // largest speed * cycle
  localparam int RW      = $clog2(NMAX + 1);      // remainder / modulus width
  localparam int CW      = $clog2(2 * CYC_MAX);   // head arithmetic width
  localparam int LW      = $clog2(RW + 1);        // modulus shift width
  localparam int NSTAGE  = 9;

  typedef struct packed {
    logic              in_range;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [FRAME_W-1:0] frame;
    logic [31:0]       psum;
    logic [64:0]       prod;
    logic [31:0]       quot;
    logic [RW-1:0]     rem;
    logic [CW-1:0]     base;
    logic [CW-1:0]     head;
    logic [CW-1:0]     t;
    logic              hit;
    logic [31:0]       h;
  } stage_t;

  // Per-column constant tables
  logic [31:0]   seed_tab [COL_CODES];
  logic [32:0]   mn_tab   [COL_CODES];
  logic [LW-1:0] ln_tab   [COL_CODES];
  logic [RW-1:0] n_tab    [COL_CODES];
  logic [32:0]   ms_tab   [COL_CODES];
  logic [1:0]    ls_tab   [COL_CODES];
  logic [CW-1:0] cyc_tab  [COL_CODES];
  logic [CW-1:0] off_tab  [COL_CODES];
  logic [CW-1:0] tail_tab [COL_CODES];

  for (genvar c = 0; c < COL_CODES; c++) begin : g_col
    localparam logic [31:0] SEED  = hash32(32'(c) * COL_MUL + COL_ADD);
    localparam int SPEED = 2 + int'(SEED % 32'd4);
    localparam int TAIL  = 3 + int'((SEED >> 8) % 32'd5);
    localparam int CYC   = ROWS + TAIL + 3;
    localparam int OFF   = int'((SEED >> 16) % 32'(CYC));
    localparam int NMOD  = SPEED * CYC;
    localparam int LN    = $clog2(NMOD);
    localparam int LS    = $clog2(SPEED);
    // Round-up reciprocals, exact for every 32-bit dividend
    localparam logic [63:0] MN =
      ((64'd1 << (32 + LN)) + 64'(NMOD) - 64'd1) / 64'(NMOD);
    localparam logic [63:0] MS =
      ((64'd1 << (32 + LS)) + 64'(SPEED) - 64'd1) / 64'(SPEED);

    assign seed_tab[c] = SEED;
    assign mn_tab[c]   = MN[32:0];
    assign ln_tab[c]   = LW'(LN);
    assign n_tab[c]    = RW'(NMOD);
    assign ms_tab[c]   = MS[32:0];
    assign ls_tab[c]   = 2'(LS);
    assign cyc_tab[c]  = CW'(CYC);
    assign off_tab[c]  = CW'(OFF);
    assign tail_tab[c] = CW'(TAIL);
  end

  // No back-pressure: a cell can start in every cycle
  assign busy = 1'b0;

  logic   vld_d  [NSTAGE];
  logic   vld_q  [NSTAGE];
  stage_t data_d [NSTAGE];
  stage_t data_q [NSTAGE];

  logic [64:0]    quot_sh;
  logic [RW+32:0] spd_prod;
  logic [RW+32:0] spd_sh;
  logic [CW-1:0]  head_sum;
  logic [CW-1:0]  row_ext;
  logic [31:0]    mix_a;
  logic [31:0]    mix_b;

  // Stage datapath
  always_comb begin
    for (int k = 1; k < NSTAGE; k++) begin
      vld_d[k]  = vld_q[k-1];
      data_d[k] = data_q[k-1];
    end

    // s0: capture the request
    vld_d[0]          = start & ~busy;
    data_d[0]         = '0;
    data_d[0].frame   = cell_i.frame_index;
    data_d[0].col     = cell_i.column;
    data_d[0].row     = cell_i.row;
    data_d[0].in_range = (32'(cell_i.column) < 32'(COLUMNS)) &&
                         (32'(cell_i.row) < 32'(ROWS));

    // s1: frame times reciprocal of speed*cycle; glyph hash partial sum
    data_d[1].prod = 65'(data_q[0].frame) * 65'(mn_tab[data_q[0].col]);
    data_d[1].psum = seed_tab[data_q[0].col] + (data_q[0].frame >> 2)
                   + 32'(data_q[0].row) * 32'(ROW_WEIGHT);

    // s2: quotient of frame by speed*cycle
    quot_sh        = data_q[1].prod >> ln_tab[data_q[1].col];
    data_d[2].quot = quot_sh[63:32];

    // s3: frame mod speed*cycle, exact in RW bits
    data_d[3].rem = data_q[2].frame[RW-1:0]
                  - RW'(data_q[2].quot[RW-1:0] * n_tab[data_q[2].col]);

    // s4: remainder divided by speed gives the head step within the cycle
    spd_prod       = (RW+33)'(data_q[3].rem) * (RW+33)'(ms_tab[data_q[3].col]);
    spd_sh         = spd_prod >> ls_tab[data_q[3].col];
    data_d[4].base = spd_sh[32 +: CW];

    // s5: add the column phase, one conditional wrap
    head_sum       = data_q[4].base + off_tab[data_q[4].col];
    data_d[5].head = (head_sum >= cyc_tab[data_q[4].col]) ?
                     head_sum - cyc_tab[data_q[4].col] : head_sum;

    // s6: trail position of this row, glyph hash input
    row_ext       = CW'(data_q[5].row);
    data_d[6].t   = data_q[5].head - row_ext;
    data_d[6].hit = (data_q[5].head >= row_ext) &&
                    ((data_q[5].head - row_ext) < tail_tab[data_q[5].col]);
    data_d[6].h   = data_q[5].psum + 32'(data_q[5].head - row_ext);

    // s7: first hash round
    mix_a       = data_q[6].h ^ (data_q[6].h >> 16);
    data_d[7].h = mix_a * HASH_MUL_A;

    // s8: second hash round
    mix_b       = data_q[7].h ^ (data_q[7].h >> 15);
    data_d[8].h = mix_b * HASH_MUL_B;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTAGE; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  // Final hash mix, style decision and pixel position
  logic [31:0] gs;
  cell_rsp_t   rsp_d;
  cell_rsp_t   rsp_q;
  logic        done_q;

  always_comb begin
    gs               = data_q[8].h ^ (data_q[8].h >> 16);
    rsp_d            = '0;
    rsp_d.style      = STYLE_BLANK;
    rsp_d.pixel_x    = {data_q[8].col, 3'b000} + PIXX_W'(1);
    rsp_d.pixel_y    = PIXY_W'({data_q[8].row, 3'b000});
    if (data_q[8].in_range && data_q[8].hit) begin
      if (data_q[8].t == '0) begin
        rsp_d.style      = STYLE_HEAD;
        rsp_d.glyph_code = glyph_of(gs[3:0]);
      end else if ((data_q[8].t < CW'(NEAR_TAIL)) || gs[KEEP_BIT]) begin
        rsp_d.style      = STYLE_NORMAL;
        rsp_d.glyph_code = glyph_of(gs[3:0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[NSTAGE-1];
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule
